@@ src/utf8d_pkg.sv @@
package utf8d_pkg;

  // result queue depth, room for the two words one byte can cause
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // group size limits
  localparam logic [2:0] GrpMax = 3'd4;

  // byte order mark bytes
  localparam logic [7:0] Bom0 = 8'hEF;
  localparam logic [7:0] Bom1 = 8'hBB;
  localparam logic [7:0] Bom2 = 8'hBF;

  // one result word
  typedef struct packed {
    logic [20:0] codepoint;
    logic [2:0]  group_length;
    logic        has_codepoint;
    logic        sequence_error;
    logic        string_done;
  } res_t;

  // words pushed by the decoder in one cycle, a first then b
  typedef struct packed {
    logic a_vld;
    logic b_vld;
    res_t res_a;
    res_t res_b;
  } push_t;

  // decode of a closed group
  typedef struct packed {
    logic        has;
    logic [20:0] cp;
  } flush_t;

  // decode a group by its byte count, the byte order mark gives nothing
  function automatic flush_t utf8d_flush(input logic [3:0][7:0] grp, input logic [2:0] n);
    flush_t f;
    f.has = 1'b1;
    f.cp  = '0;
    case (n)
      3'd0: begin
        f.has = 1'b0;
      end
      3'd1: begin
        f.cp = 21'({grp[0][6:0]});
      end
      3'd2: begin
        f.cp = 21'({grp[0][4:0], grp[1][5:0]});
      end
      3'd3: begin
        f.cp = 21'({grp[0][3:0], grp[1][5:0], grp[2][5:0]});
        if (grp[0] == Bom0 && grp[1] == Bom1 && grp[2] == Bom2) begin
          f.has = 1'b0;
        end
      end
      default: begin
        f.cp = {grp[0][2:0], grp[1][5:0], grp[2][5:0], grp[3][5:0]};
      end
    endcase
    return f;
  endfunction

endpackage

@@ src/utf8d_decode.sv @@
module utf8d_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  input  logic           in_eos,
  output utf8d_pkg::push_t push
);
  import utf8d_pkg::*;

  logic [3:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            aborted_r, aborted_nxt;

  logic   nz, eos, closing;
  flush_t flush_old;

  assign nz        = (in_byte != 8'h00);
  assign eos       = in_eos | ~nz;
  assign closing   = ~in_byte[7] | (in_byte[7:6] == 2'b11);
  assign flush_old = utf8d_flush(bytes_r, cnt_r);

  // group update and result words for one byte
  always_comb begin
    logic [3:0][7:0] bytes_eff;
    logic [2:0]      cnt_eff;
    logic            stop;
    flush_t          flush_new;
    bytes_eff   = bytes_r;
    cnt_eff     = cnt_r;
    stop        = 1'b0;
    flush_new   = '0;
    bytes_nxt   = bytes_r;
    cnt_nxt     = cnt_r;
    aborted_nxt = aborted_r;
    push.a_vld  = 1'b0;
    push.b_vld  = 1'b0;
    push.res_a  = '{codepoint: flush_old.cp, group_length: cnt_r, has_codepoint: 1'b1,
                    sequence_error: 1'b0, string_done: 1'b0};
    push.res_b  = '0;
    if (in_fire) begin
      if (aborted_r) begin
        // aborted string, only the end byte reports
        if (eos) begin
          push.b_vld                = 1'b1;
          push.res_b.sequence_error = 1'b1;
          push.res_b.string_done    = 1'b1;
          cnt_nxt                   = '0;
          aborted_nxt               = 1'b0;
        end
      end else begin
        if (nz) begin
          // closing byte flushes the pending group
          if (closing && cnt_r != 3'd0) begin
            push.a_vld = flush_old.has;
            cnt_eff    = '0;
          end
          if (cnt_eff >= GrpMax) begin
            // fifth byte, drop the group and abort
            push.b_vld                = 1'b1;
            push.res_b.sequence_error = 1'b1;
            push.res_b.string_done    = eos;
            cnt_nxt                   = '0;
            aborted_nxt               = ~eos;
            stop                      = 1'b1;
          end else begin
            bytes_eff[cnt_eff[1:0]] = in_byte;
            cnt_eff                 = cnt_eff + 3'd1;
          end
        end
        if (!stop) begin
          bytes_nxt = bytes_eff;
          cnt_nxt   = cnt_eff;
          // end of string flushes what is left
          if (eos) begin
            flush_new  = utf8d_flush(bytes_eff, cnt_eff);
            push.b_vld = 1'b1;
            if (flush_new.has) begin
              push.res_b = '{codepoint: flush_new.cp, group_length: cnt_eff,
                             has_codepoint: 1'b1, sequence_error: 1'b0, string_done: 1'b1};
            end else begin
              push.res_b.string_done = 1'b1;
            end
            cnt_nxt = '0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      aborted_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      aborted_r <= aborted_nxt;
    end
  end

  // group bytes, only read below the count
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

@@ src/utf8d_out_fifo.sv @@
module utf8d_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  utf8d_pkg::push_t push,
  output logic             room,
  output logic             out_tvalid,
  input  logic             out_tready,
  output utf8d_pkg::res_t  out_res
);
  import utf8d_pkg::*;

  res_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       push_n;
  res_t             first_w, second_w;

  assign pop        = out_tvalid & out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_res    = mem[rd_ptr_r];
  assign room       = (cnt_r <= QCntW'(QDepth - 2));
  assign push_n     = {1'b0, push.a_vld} + {1'b0, push.b_vld};
  assign first_w    = push.a_vld ? push.res_a : push.res_b;
  assign second_w   = push.res_b;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    cnt_nxt    = cnt_r + QCntW'(push_n) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // word storage, up to two writes a cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= first_w;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + QPtrW'(1)] <= second_w;
    end
  end

endmodule

@@ src/utf8_byte_stream_decoder_top.sv @@
// UTF-8 byte stream decoder
//
// in channel: one string byte per word in in_tdata, in_tlast on the last byte
// of the string; a zero byte also ends the string and is not stored.
// out channel: one word per decoded codepoint, per error and per string end;
// out_tlast marks the last word caused by the end byte, out_tuser tells a
// codepoint word from an error word.
// A byte is taken in a cycle in which in_tready is high; its words enter a
// four-word result queue at the next edge. One byte per cycle is sustained
// while the queue has room; a byte that both closes a group and ends the
// string makes two words, which drain one per cycle while out_tready is high.
// in_tready drops only while the result queue holds more than two words, so
// a stalled receiver backs up the input after the queue fills.
// Reset clears the pending group, the abort flag and the queue; after the end
// of each string the group state returns to its reset values.
module utf8_byte_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] codepoint, [23:21] group_length
  output logic [1:0]  out_tuser,  // [0] has_codepoint, [1] sequence_error
  output logic        out_tlast   // string_done
);
  import utf8d_pkg::*;

  push_t push;
  res_t  res;
  logic  room;
  logic  in_fire;

  assign in_tready = room;
  assign in_fire   = in_tvalid & in_tready;

  // group state and decode
  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .push    (push)
  );

  // result queue
  utf8d_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // pack the result word
  assign out_tdata = {res.group_length, res.codepoint};
  assign out_tuser = {res.sequence_error, res.has_codepoint};
  assign out_tlast = res.string_done;

endmodule
